// File: rtl/asrw_pkg.sv
// ----------------------------------------------------------------------------
// Adapter register window package
// Item and result types, command codes, cell indexes and masks shared by the
// register window modules.
// ----------------------------------------------------------------------------
`default_nettype none

package asrw_pkg;

    localparam logic [2:0] CMD_READ        = 3'd0;
    localparam logic [2:0] CMD_WRITE       = 3'd1;
    localparam logic [2:0] CMD_VBLANK_ON   = 3'd2;
    localparam logic [2:0] CMD_VBLANK_OFF  = 3'd3;
    localparam logic [2:0] CMD_MASTER_ACK  = 3'd4;
    localparam logic [2:0] CMD_SLAVE_ACK   = 3'd5;
    localparam logic [2:0] CMD_FIFO_POP    = 3'd6;
    localparam logic [2:0] CMD_RESERVED    = 3'd7;

    localparam logic       CFG_CART_SIZE   = 1'b0;
    localparam logic       CFG_BOOT_ROM    = 1'b1;

    // Word cell indexes (byte offset divided by two).
    localparam logic [4:0] CELL_CTRL       = 5'h00;
    localparam logic [4:0] CELL_INT        = 5'h01;
    localparam logic [4:0] CELL_BANK       = 5'h02;
    localparam logic [4:0] CELL_REQ        = 5'h03;
    localparam logic [4:0] CELL_SRC_HI     = 5'h04;
    localparam logic [4:0] CELL_SRC_LO     = 5'h05;
    localparam logic [4:0] CELL_DST_HI     = 5'h06;
    localparam logic [4:0] CELL_DST_LO     = 5'h07;
    localparam logic [4:0] CELL_LENGTH     = 5'h08;
    localparam logic [4:0] CELL_FIFO       = 5'h09;
    localparam logic [4:0] CELL_PWM_CTRL   = 5'h18;
    localparam logic [4:0] CELL_PWM_PERIOD = 5'h19;
    localparam logic [1:0] CELL_SHARED_TAG = 2'b10;

    localparam logic [15:0] CTRL_WRITE_MASK = 16'hFF7C;
    localparam logic [15:0] CTRL_VBLANK     = 16'h0080;
    localparam logic [15:0] CTRL_READ_MASK  = 16'hFFFC;
    localparam logic [6:0]  BANK_WINDOW_64K = 7'd16;
    localparam logic [6:0]  CART_SIZE_RESET = 7'd64;

    typedef struct packed {
        logic [2:0] cmd;
        logic [5:0] byte_offset;
        logic [7:0] write_byte;
    } t_item;

    typedef struct packed {
        logic [7:0]  read_byte;
        logic        slave_reset_held;
        logic        raise_master_cmd;
        logic        raise_slave_cmd;
        logic        vblank_irq;
        logic        map_boot_overlay;
        logic        bank_retarget;
        logic [1:0]  bank_now;
        logic        fifo_push_valid;
        logic [15:0] fifo_push_word;
        logic        fifo_overflow;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/adapter_system_register_window_core.sv
// An accepted item waits in the input register until the result register is empty
// or drains; its result is then registered. Throughput: one item per cycle while
// i_out_ready is high, set by the single decode and update stage between the input
// register and the result register. Reset: synchronous, active low; the valid flags
// and the window state are reset, and items are accepted once reset is released.
// ----------------------------------------------------------------------------
// Adapter system register window core
// Main CPU register window of the adapter with an input register, the register
// state stage and a result register.
// ----------------------------------------------------------------------------
`default_nettype none

module adapter_system_register_window_core #(
    parameter int FIFO_DEPTH = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [2:0]  i_cmd,
    input  wire  [5:0]  i_byte_offset,
    input  wire  [7:0]  i_write_byte,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [7:0]  o_read_byte,
    output logic        o_slave_reset_held,
    output logic        o_raise_master_cmd,
    output logic        o_raise_slave_cmd,
    output logic        o_vblank_irq,
    output logic        o_map_boot_overlay,
    output logic        o_bank_retarget,
    output logic [1:0]  o_bank_now,
    output logic        o_fifo_push_valid,
    output logic [15:0] o_fifo_push_word,
    output logic        o_fifo_overflow,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire         i_cfg_index,
    input  wire  [6:0]  i_cfg_data
);
    import asrw_pkg::*;

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_out;
    t_result w_result;
    logic    w_step;
    logic    w_in_accept;

    assign w_step      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_step;
    assign w_in_accept = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    asrw_regs #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_item      (r_item),
        .i_cfg_write (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid <= w_in_accept || (r_in_valid && !w_step);
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_item.cmd         <= i_cmd;
            r_item.byte_offset <= i_byte_offset;
            r_item.write_byte  <= i_write_byte;
        end
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_read_byte        = r_out.read_byte;
    assign o_slave_reset_held = r_out.slave_reset_held;
    assign o_raise_master_cmd = r_out.raise_master_cmd;
    assign o_raise_slave_cmd  = r_out.raise_slave_cmd;
    assign o_vblank_irq       = r_out.vblank_irq;
    assign o_map_boot_overlay = r_out.map_boot_overlay;
    assign o_bank_retarget    = r_out.bank_retarget;
    assign o_bank_now         = r_out.bank_now;
    assign o_fifo_push_valid  = r_out.fifo_push_valid;
    assign o_fifo_push_word   = r_out.fifo_push_word;
    assign o_fifo_overflow    = r_out.fifo_overflow;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid && !i_out_ready))
        else $error("input stalled while the result register could drain");

    a_push_excludes_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_fifo_push_valid && o_fifo_overflow))
        else $error("push and overflow reported for the same item");

    a_push_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_fifo_push_valid) |-> (o_fifo_push_word == 16'h0000))
        else $error("push word nonzero without a push");

    a_step_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> o_out_valid)
        else $error("processed item did not reach the result register");

endmodule

`default_nettype wire

// File: rtl/asrw_regs.sv
// ----------------------------------------------------------------------------
// Adapter register window state
// Holds the window's registers and executes one item per step, producing the
// result item from the current state.
// ----------------------------------------------------------------------------
`default_nettype none

module asrw_regs #(
    parameter int FIFO_DEPTH = 8
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_step,
    input  asrw_pkg::t_item       i_item,
    input  wire                   i_cfg_write,
    input  wire                   i_cfg_index,
    input  wire  [6:0]            i_cfg_data,
    output asrw_pkg::t_result     o_result
);
    import asrw_pkg::*;

    localparam int FILL_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(FIFO_DEPTH);

    logic [6:0]        r_cart_size;
    logic              r_boot_rom;
    logic [15:0]       r_ctrl,       n_ctrl;
    logic              r_enabled,    n_enabled;
    logic              r_slave_rst,  n_slave_rst;
    logic              r_master_pnd, n_master_pnd;
    logic              r_slave_pnd,  n_slave_pnd;
    logic [1:0]        r_bank,       n_bank;
    logic [2:0]        r_req,        n_req;
    logic [7:0]        r_src_hi,     n_src_hi;
    logic [15:0]       r_src_lo,     n_src_lo;
    logic [7:0]        r_dst_hi,     n_dst_hi;
    logic [15:0]       r_dst_lo,     n_dst_lo;
    logic [15:0]       r_length,     n_length;
    logic [FILL_W-1:0] r_fill,       n_fill;
    logic [7:0]        r_pend_hi,    n_pend_hi;
    logic [15:0]       r_shared [8];
    logic [15:0]       n_shared [8];
    logic [15:0]       r_pwm_ctrl,   n_pwm_ctrl;
    logic [15:0]       r_pwm_period, n_pwm_period;

    logic [4:0]        w_cell;
    logic              w_odd;
    logic [15:0]       w_cur;
    logic [15:0]       w_nxt;
    logic [4:0]        w_window;
    t_result           w_res;

    assign w_cell   = i_item.byte_offset[5:1];
    assign w_odd    = i_item.byte_offset[0];
    assign w_window = (r_cart_size > BANK_WINDOW_64K) ? BANK_WINDOW_64K[4:0]
                                                      : r_cart_size[4:0];

    always_comb begin
        w_cur = 16'h0000;
        unique case (w_cell)
            CELL_CTRL: begin
                w_cur    = r_ctrl & CTRL_READ_MASK;
                w_cur[0] = r_enabled;
                w_cur[1] = ~r_slave_rst;
            end
            CELL_INT:        w_cur = {14'h0000, r_slave_pnd, r_master_pnd};
            CELL_BANK:       w_cur = {14'h0000, r_bank};
            CELL_REQ:        w_cur = {8'h00, (r_fill >= FILL_MAX), 4'h0, r_req};
            CELL_SRC_HI:     w_cur = {8'h00, r_src_hi};
            CELL_SRC_LO:     w_cur = r_src_lo;
            CELL_DST_HI:     w_cur = {8'h00, r_dst_hi};
            CELL_DST_LO:     w_cur = r_dst_lo;
            CELL_LENGTH:     w_cur = r_length;
            CELL_PWM_CTRL:   w_cur = r_pwm_ctrl;
            CELL_PWM_PERIOD: w_cur = r_pwm_period;
            default: begin
                if (w_cell[4:3] == CELL_SHARED_TAG) begin
                    w_cur = r_shared[w_cell[2:0]];
                end
            end
        endcase
        w_nxt = w_odd ? {w_cur[15:8], i_item.write_byte}
                      : {i_item.write_byte, w_cur[7:0]};
    end

    always_comb begin
        n_ctrl       = r_ctrl;
        n_enabled    = r_enabled;
        n_slave_rst  = r_slave_rst;
        n_master_pnd = r_master_pnd;
        n_slave_pnd  = r_slave_pnd;
        n_bank       = r_bank;
        n_req        = r_req;
        n_src_hi     = r_src_hi;
        n_src_lo     = r_src_lo;
        n_dst_hi     = r_dst_hi;
        n_dst_lo     = r_dst_lo;
        n_length     = r_length;
        n_fill       = r_fill;
        n_pend_hi    = r_pend_hi;
        n_shared     = r_shared;
        n_pwm_ctrl   = r_pwm_ctrl;
        n_pwm_period = r_pwm_period;
        w_res        = '0;

        unique case (i_item.cmd)
            CMD_READ: begin
                w_res.read_byte = w_odd ? w_cur[7:0] : w_cur[15:8];
            end
            CMD_WRITE: begin
                unique case (w_cell)
                    CELL_CTRL: begin
                        n_ctrl = (w_nxt & CTRL_WRITE_MASK) | (r_ctrl & CTRL_VBLANK);
                        if (w_nxt[0] && !r_enabled) begin
                            n_enabled              = 1'b1;
                            w_res.map_boot_overlay = r_boot_rom;
                        end
                        if (w_nxt[0] && w_nxt[1]) begin
                            n_slave_rst = 1'b0;
                        end else if (!w_nxt[1]) begin
                            n_slave_rst = 1'b1;
                        end
                    end
                    CELL_INT: begin
                        if (w_nxt[0]) begin
                            w_res.raise_master_cmd = ~r_master_pnd;
                            n_master_pnd           = 1'b1;
                        end
                        if (w_nxt[1]) begin
                            w_res.raise_slave_cmd = ~r_slave_pnd;
                            n_slave_pnd           = 1'b1;
                        end
                    end
                    CELL_BANK: begin
                        n_bank              = w_nxt[1:0];
                        w_res.bank_retarget = (r_cart_size != 7'd0) &&
                            (({2'b00, w_nxt[1:0], 4'h0} + {3'b000, w_window})
                             <= {1'b0, r_cart_size});
                    end
                    CELL_REQ: begin
                        n_req = w_nxt[2:0];
                        if (!w_nxt[2]) begin
                            n_fill = '0;
                        end
                    end
                    CELL_SRC_HI:     n_src_hi     = w_nxt[7:0];
                    CELL_SRC_LO:     n_src_lo     = {w_nxt[15:1], 1'b0};
                    CELL_DST_HI:     n_dst_hi     = w_nxt[7:0];
                    CELL_DST_LO:     n_dst_lo     = {w_nxt[15:1], 1'b0};
                    CELL_LENGTH:     n_length     = w_nxt;
                    CELL_PWM_CTRL:   n_pwm_ctrl   = w_nxt;
                    CELL_PWM_PERIOD: n_pwm_period = w_nxt;
                    CELL_FIFO: begin
                        if (!w_odd) begin
                            n_pend_hi = i_item.write_byte;
                        end else if (r_req[2]) begin
                            if (r_fill >= FILL_MAX) begin
                                w_res.fifo_overflow = 1'b1;
                            end else begin
                                n_fill                = r_fill + 1'b1;
                                w_res.fifo_push_valid = 1'b1;
                                w_res.fifo_push_word  = {r_pend_hi, i_item.write_byte};
                            end
                        end
                    end
                    default: begin
                        if (w_cell[4:3] == CELL_SHARED_TAG) begin
                            n_shared[w_cell[2:0]] = w_nxt;
                        end
                    end
                endcase
            end
            CMD_VBLANK_ON: begin
                n_ctrl           = r_ctrl | CTRL_VBLANK;
                w_res.vblank_irq = 1'b1;
            end
            CMD_VBLANK_OFF: n_ctrl       = r_ctrl & ~CTRL_VBLANK;
            CMD_MASTER_ACK: n_master_pnd = 1'b0;
            CMD_SLAVE_ACK:  n_slave_pnd  = 1'b0;
            CMD_FIFO_POP: begin
                if (r_fill != '0) begin
                    n_fill = r_fill - 1'b1;
                end
            end
            default: begin
            end
        endcase

        w_res.slave_reset_held = n_slave_rst;
        w_res.bank_now         = n_bank;
    end

    assign o_result = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cart_size  <= CART_SIZE_RESET;
            r_boot_rom   <= 1'b1;
            r_ctrl       <= 16'h0000;
            r_enabled    <= 1'b0;
            r_slave_rst  <= 1'b1;
            r_master_pnd <= 1'b0;
            r_slave_pnd  <= 1'b0;
            r_bank       <= 2'b00;
            r_req        <= 3'b000;
            r_src_hi     <= 8'h00;
            r_src_lo     <= 16'h0000;
            r_dst_hi     <= 8'h00;
            r_dst_lo     <= 16'h0000;
            r_length     <= 16'h0000;
            r_fill       <= '0;
            r_pend_hi    <= 8'h00;
            r_shared     <= '{default: 16'h0000};
            r_pwm_ctrl   <= 16'h0000;
            r_pwm_period <= 16'h0000;
        end else begin
            if (i_cfg_write) begin
                unique case (i_cfg_index)
                    CFG_CART_SIZE: r_cart_size <= i_cfg_data;
                    CFG_BOOT_ROM:  r_boot_rom  <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (i_step) begin
                r_ctrl       <= n_ctrl;
                r_enabled    <= n_enabled;
                r_slave_rst  <= n_slave_rst;
                r_master_pnd <= n_master_pnd;
                r_slave_pnd  <= n_slave_pnd;
                r_bank       <= n_bank;
                r_req        <= n_req;
                r_src_hi     <= n_src_hi;
                r_src_lo     <= n_src_lo;
                r_dst_hi     <= n_dst_hi;
                r_dst_lo     <= n_dst_lo;
                r_length     <= n_length;
                r_fill       <= n_fill;
                r_pend_hi    <= n_pend_hi;
                r_shared     <= n_shared;
                r_pwm_ctrl   <= n_pwm_ctrl;
                r_pwm_period <= n_pwm_period;
            end
        end
    end

endmodule

`default_nettype wire
